@@ design/csje_pkg.sv @@
package csje_pkg;

    // Field widths fixed by the interface
    localparam int KIND_W       = 4;
    localparam int LEN_W        = 28;
    localparam int OVH_OUT_W    = 32;
    localparam int JCNT_W       = 16;
    localparam int MIN_OVH_W    = 32;
    localparam int MIN_JCNT_W   = 16;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 1;

    // Defaults for the top-level parameters
    localparam int DEF_LENGTH_BITS   = 28;
    localparam int DEF_OVERHANG_BITS = 32;
    localparam int DEF_QUEUE_DEPTH   = 4;

    // Reset values of the configuration registers
    localparam logic [MIN_OVH_W-1:0]  MIN_OVH_RST  = 32'd8;
    localparam logic [MIN_JCNT_W-1:0] MIN_JCNT_RST = 16'd2;

    // CIGAR operation codes that matter here; everything else is ignored
    localparam logic [KIND_W-1:0] KIND_MATCH = 4'd0;
    localparam logic [KIND_W-1:0] KIND_INS   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_DEL   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_SKIP  = 4'd3;

    localparam logic REC_JUNCTION = 1'b0;
    localparam logic REC_SUMMARY  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_OVERHANG  = 1'b0,
        CFG_MIN_JUNCTIONS = 1'b1
    } cfg_reg_e;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  op_length;
        logic              last_op;
    } in_item_t;

    typedef struct packed {
        logic                 record_type;
        logic [OVH_OUT_W-1:0] left_overhang;
        logic [LEN_W-1:0]     intron_length;
        logic [OVH_OUT_W-1:0] right_overhang;
        logic                 short_overhang;
        logic [JCNT_W-1:0]    junction_count;
        logic                 spliced;
        logic                 rejected;
        logic                 any_short;
        logic                 too_many;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        logic [OVH_OUT_W-1:0] left;
        logic [LEN_W-1:0]     intron;
        logic [OVH_OUT_W-1:0] right;
        logic                 short_ovh;
    } junc_t;

    typedef struct packed {
        logic [JCNT_W-1:0] count;
        logic              spliced;
        logic              rejected;
        logic              any_short;
        logic              too_many;
    } summ_t;

    // One classified op: up to two junction records and a summary
    typedef struct packed {
        logic  j0_en;
        logic  j1_en;
        logic  summ_en;
        junc_t j0;
        junc_t j1;
        summ_t summ;
    } cmd_t;

endpackage

@@ design/cigar_splice_junction_extractor_top.sv @@
// CIGAR splice junction extractor. Feed the CIGAR ops of one aligned read
// per beat on s_, with last_op set on the read's final op. Match lengths are
// summed (saturating) between skips; each skip closes a junction whose record
// (left overhang, intron length, right overhang, short flag) comes out on m_
// once its right overhang is known, i.e. at the next skip or at the read's
// last op, followed there by a read summary. Insertions and deletions reject
// the read; junction records already sent for a rejected read are void, as
// the summary says. Clips, pad, eq, diff and unused codes are ignored.
// Rate: one op accepted per cycle. Each op becomes 0 to 3 result beats; the
// result side sends one beat per cycle while m_ready is high, so ops yielding
// two or three beats hold the back end, and a QUEUE_DEPTH-entry command
// queue between front and back absorbs such bursts. s_ready drops only when
// that queue is full. An op's results pass through that queue and then the
// output register on their way to m_. Config (min_overhang at index 0,
// reset 8; min_junctions at index 1, reset 2) is written through the cfg_
// port and must only change between reads while the block is idle.
module cigar_splice_junction_extractor_top #(
    parameter int LENGTH_BITS   = csje_pkg::DEF_LENGTH_BITS,
    parameter int OVERHANG_BITS = csje_pkg::DEF_OVERHANG_BITS,
    parameter int QUEUE_DEPTH   = csje_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_wr_en,
    input  logic [csje_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csje_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // CIGAR op beats in
    input  logic                            s_valid,
    output logic                            s_ready,
    input  csje_pkg::in_item_t              s_item,
    // Junction and summary beats out
    output logic                            m_valid,
    input  logic                            m_ready,
    output csje_pkg::out_item_t             m_item
);
    import csje_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    logic head_valid;
    cmd_t head_cmd;

    // Front: config registers, per-read state, op classification
    csje_front #(
        .LENGTH_BITS   (LENGTH_BITS),
        .OVERHANG_BITS (OVERHANG_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    // Commands waiting for the back end; ops with no result are not queued
    csje_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back: expands a command into its beats behind an output register
    csje_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

@@ design/csje_front.sv @@
module csje_front #(
    parameter int LENGTH_BITS   = csje_pkg::DEF_LENGTH_BITS,
    parameter int OVERHANG_BITS = csje_pkg::DEF_OVERHANG_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [csje_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csje_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  csje_pkg::in_item_t                  s_item,
    input  logic                                q_full,
    output logic                                q_push,
    output csje_pkg::cmd_t                      q_cmd
);
    import csje_pkg::*;

    localparam int SUM_W = ((OVERHANG_BITS > LEN_W) ? OVERHANG_BITS : LEN_W) + 1;
    localparam int CMP_W = (OVERHANG_BITS > MIN_OVH_W) ? OVERHANG_BITS : MIN_OVH_W;
    localparam logic [LEN_W-1:0] LenMask =
        (LENGTH_BITS >= LEN_W) ? {LEN_W{1'b1}} : LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);
    localparam logic [OVERHANG_BITS-1:0] OvhMax = {OVERHANG_BITS{1'b1}};
    localparam logic [JCNT_W-1:0] JcntMax = {JCNT_W{1'b1}};

    logic [MIN_OVH_W-1:0]     min_ovh_reg;
    logic [MIN_JCNT_W-1:0]    min_jcnt_reg;

    logic [OVERHANG_BITS-1:0] accum_reg, accum_next;
    logic [OVERHANG_BITS-1:0] pend_left_reg, pend_left_next;
    logic [LEN_W-1:0]         pend_intron_reg, pend_intron_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic                     rejected_reg, rejected_next;
    logic                     short_seen_reg, short_seen_next;
    logic [JCNT_W-1:0]        jcnt_reg, jcnt_next;

    logic [LEN_W-1:0]         len;
    logic                     is_match, is_indel, is_skip;
    logic [SUM_W-1:0]         sum;
    logic [OVERHANG_BITS-1:0] accum_sat;
    logic                     prev_en, last_en;
    logic                     sh_prev, sh_last;
    logic                     spliced;
    logic                     accept;

    function automatic logic below_min(logic [OVERHANG_BITS-1:0] v,
                                       logic [MIN_OVH_W-1:0] m);
        return CMP_W'(v) < CMP_W'(m);
    endfunction

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_ovh_reg  <= MIN_OVH_RST;
            min_jcnt_reg <= MIN_JCNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_MIN_OVERHANG:  min_ovh_reg  <= cfg_wr_data[MIN_OVH_W-1:0];
                CFG_MIN_JUNCTIONS: min_jcnt_reg <= cfg_wr_data[MIN_JCNT_W-1:0];
            endcase
        end
    end

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        len      = s_item.op_length & LenMask;
        is_match = !rejected_reg && (s_item.kind == KIND_MATCH);
        is_indel = !rejected_reg && ((s_item.kind == KIND_INS) || (s_item.kind == KIND_DEL));
        is_skip  = !rejected_reg && (s_item.kind == KIND_SKIP);

        sum       = SUM_W'(accum_reg) + SUM_W'(len);
        accum_sat = (sum > SUM_W'(OvhMax)) ? OvhMax : sum[OVERHANG_BITS-1:0];

        // State after this op, before any end-of-read clear
        accum_next       = is_match ? accum_sat : (is_skip ? '0 : accum_reg);
        pend_left_next   = is_skip ? accum_reg : pend_left_reg;
        pend_intron_next = is_skip ? len : pend_intron_reg;
        pend_valid_next  = is_skip ? 1'b1 : (is_indel ? 1'b0 : pend_valid_reg);
        rejected_next    = rejected_reg || is_indel;
        jcnt_next        = (is_skip && (jcnt_reg != JcntMax)) ? jcnt_reg + 1'b1 : jcnt_reg;

        // Skip closes the previous junction; read end closes the pending one
        prev_en = is_skip && pend_valid_reg;
        last_en = s_item.last_op && pend_valid_next && !rejected_next;
        sh_prev = below_min(pend_left_reg, min_ovh_reg) || below_min(accum_reg, min_ovh_reg);
        sh_last = below_min(pend_left_next, min_ovh_reg) || below_min(accum_next, min_ovh_reg);
        short_seen_next = short_seen_reg || (prev_en && sh_prev) || (last_en && sh_last);

        spliced = (jcnt_next != '0) && !rejected_next;

        q_cmd.j0_en   = prev_en || last_en;
        q_cmd.j1_en   = prev_en && last_en;
        q_cmd.summ_en = s_item.last_op;

        q_cmd.j1.left      = OVH_OUT_W'(pend_left_next);
        q_cmd.j1.intron    = pend_intron_next;
        q_cmd.j1.right     = OVH_OUT_W'(accum_next);
        q_cmd.j1.short_ovh = sh_last;

        if (prev_en) begin
            q_cmd.j0.left      = OVH_OUT_W'(pend_left_reg);
            q_cmd.j0.intron    = pend_intron_reg;
            q_cmd.j0.right     = OVH_OUT_W'(accum_reg);
            q_cmd.j0.short_ovh = sh_prev;
        end else begin
            q_cmd.j0 = q_cmd.j1;
        end

        q_cmd.summ.count     = rejected_next ? '0 : jcnt_next;
        q_cmd.summ.spliced   = spliced;
        q_cmd.summ.rejected  = rejected_next;
        q_cmd.summ.any_short = spliced && short_seen_next;
        q_cmd.summ.too_many  = spliced && (jcnt_next >= min_jcnt_reg);

        q_push = accept && (q_cmd.j0_en || q_cmd.summ_en);
    end

    // Per-read state
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_item.last_op)) begin
            accum_reg       <= '0;
            pend_left_reg   <= '0;
            pend_intron_reg <= '0;
            pend_valid_reg  <= 1'b0;
            rejected_reg    <= 1'b0;
            short_seen_reg  <= 1'b0;
            jcnt_reg        <= '0;
        end else if (accept) begin
            accum_reg       <= accum_next;
            pend_left_reg   <= pend_left_next;
            pend_intron_reg <= pend_intron_next;
            pend_valid_reg  <= pend_valid_next;
            rejected_reg    <= rejected_next;
            short_seen_reg  <= short_seen_next;
            jcnt_reg        <= jcnt_next;
        end
    end

endmodule

@@ design/csje_queue.sv @@
module csje_queue #(
    parameter int DEPTH = csje_pkg::DEF_QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  csje_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output csje_pkg::cmd_t head_cmd
);
    import csje_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full       = (cnt_reg == FullCnt);
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

@@ design/csje_back.sv @@
module csje_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  csje_pkg::cmd_t      head_cmd,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output csje_pkg::out_item_t m_item
);
    import csje_pkg::*;

    // done_reg marks beats of the head command already sent: {summary, j1, j0}
    logic [2:0] done_reg;
    logic [2:0] pend, sel, remain;
    logic       m_valid_reg;
    out_item_t  m_item_reg;
    out_item_t  beat;
    logic       load;

    always_comb begin
        pend   = {head_cmd.summ_en, head_cmd.j1_en, head_cmd.j0_en} & ~done_reg;
        sel    = pend & (~pend + 3'd1);
        remain = pend & ~sel;

        beat = '0;
        case (sel)
            3'b001: begin
                beat.record_type    = REC_JUNCTION;
                beat.left_overhang  = head_cmd.j0.left;
                beat.intron_length  = head_cmd.j0.intron;
                beat.right_overhang = head_cmd.j0.right;
                beat.short_overhang = head_cmd.j0.short_ovh;
            end
            3'b010: begin
                beat.record_type    = REC_JUNCTION;
                beat.left_overhang  = head_cmd.j1.left;
                beat.intron_length  = head_cmd.j1.intron;
                beat.right_overhang = head_cmd.j1.right;
                beat.short_overhang = head_cmd.j1.short_ovh;
            end
            default: begin
                beat.record_type    = REC_SUMMARY;
                beat.junction_count = head_cmd.summ.count;
                beat.spliced        = head_cmd.summ.spliced;
                beat.rejected       = head_cmd.summ.rejected;
                beat.any_short      = head_cmd.summ.any_short;
                beat.too_many       = head_cmd.summ.too_many;
            end
        endcase
        beat.last = (remain == 3'b000);

        load = head_valid && (!m_valid_reg || m_ready);
        pop  = load && (remain == 3'b000);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_item_reg <= beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            done_reg    <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                done_reg    <= pop ? 3'b000 : (done_reg | sel);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
